[design/ctlm_pkg.sv]
// Package for the cache tag latency model: payload structs, register indexes,
// state encoding and default geometry. No dependencies.
`default_nettype none
package ctlm_pkg;

  localparam int unsigned NumWaysDef  = 4;
  localparam int unsigned NumSetsDef  = 64;
  localparam int unsigned LineBitsDef = 6;
  localparam int unsigned AddrWidthDef = 32;

  localparam int unsigned AgeW = 32;
  localparam int unsigned LatW = 20;
  localparam int unsigned PaddrW = 5;

  typedef enum logic [2:0] {
    RegCacheEnable  = 3'd0,
    RegReadLat      = 3'd1,
    RegWriteLat     = 3'd2,
    RegTagLat       = 3'd3,
    RegBurst        = 3'd4,
    RegWriteBack    = 3'd5,
    RegAllocOnWrite = 3'd6,
    RegInvOnWrite   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLookup,
    StOut
  } state_e;

  typedef struct packed {
    logic        op;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [LatW-1:0] latency;
    logic            hit;
    logic            allocated;
    logic            evicted;
    logic            dirty_evicted;
    logic            invalidated;
  } rsp_t;

  typedef struct packed {
    logic        cache_enable;
    logic [15:0] read_latency;
    logic [15:0] write_latency;
    logic [15:0] tag_latency;
    logic [15:0] line_burst_cycles;
    logic        write_back_mode;
    logic        allocate_on_write;
    logic        invalidate_on_write;
  } cfg_t;

endpackage
`default_nettype wire

[design/cache_tag_latency_model.sv]
// Top level of the cache tag latency model: set memory, lookup and update.
// Depends on ctlm_pkg and ctlm_regs.
//
// For each accepted transaction the set's row (all ways) is read
// from one synchronous memory, the ways are compared and updated and the row is
// written back, then the result is held in an output register. One transaction is
// in flight at a time: no new transaction is accepted until the result has been
// taken. After reset a clearing pass writes every set once, during which no
// transaction is accepted.
`default_nettype none
module cache_tag_latency_model #(
  parameter int unsigned NUM_WAYS   = ctlm_pkg::NumWaysDef,
  parameter int unsigned NUM_SETS   = ctlm_pkg::NumSetsDef,
  parameter int unsigned LINE_BITS  = ctlm_pkg::LineBitsDef,
  parameter int unsigned ADDR_WIDTH = ctlm_pkg::AddrWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire ctlm_pkg::req_t              in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output ctlm_pkg::rsp_t                   out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ctlm_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  localparam int unsigned SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SetBits = $clog2(NUM_SETS);
  localparam int unsigned LineW = ADDR_WIDTH - LINE_BITS;
  localparam int unsigned TagW = LineW - SetBits;
  localparam int unsigned WayW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned AgeW = ctlm_pkg::AgeW;
  localparam int unsigned LatW = ctlm_pkg::LatW;

  typedef struct packed {
    logic            valid;
    logic            dirty;
    logic [TagW-1:0] tag;
    logic [AgeW-1:0] age;
  } way_t;
  typedef way_t [NUM_WAYS-1:0] row_t;

  ctlm_pkg::cfg_t cfg;

  ctlm_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  row_t mem [NUM_SETS];
  row_t rd_row_q;
  logic wr_en;
  logic [SetW-1:0] wr_addr;
  row_t wr_row;

  ctlm_pkg::state_e state_q, state_d;
  logic [SetW:0] clr_cnt_q;
  logic op_q;
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  ctlm_pkg::rsp_t rsp_q, rsp_d;

  logic [LineW-1:0] in_line;
  logic [SetW-1:0] in_set;
  logic in_acc;

  assign in_line = in_data_i.address[ADDR_WIDTH-1:LINE_BITS];
  always_comb begin
    in_set = '0;
    if (NUM_SETS > 1) in_set = in_line[SetW-1:0];
  end
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ctlm_pkg::StIdle);
  assign out_valid_o = (state_q == ctlm_pkg::StOut);
  assign out_data_o = rsp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    rd_row_q <= mem[in_set];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_data_i.op;
      set_q <= in_set;
      tag_q <= in_line[LineW-1:SetBits];
    end
    if (state_q == ctlm_pkg::StLookup) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ctlm_pkg::StClear;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ctlm_pkg::StClear) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctlm_pkg::StClear:
        if (clr_cnt_q == (SetW+1)'(NUM_SETS - 1)) state_d = ctlm_pkg::StIdle;
      ctlm_pkg::StIdle:   if (in_acc) state_d = ctlm_pkg::StLookup;
      ctlm_pkg::StLookup: state_d = ctlm_pkg::StOut;
      ctlm_pkg::StOut:    if (!out_stall_i) state_d = ctlm_pkg::StIdle;
      default:            state_d = ctlm_pkg::StIdle;
    endcase
  end

  // Lookup and update of one row; ways are walked in order as in a scan.
  row_t new_row;
  always_comb begin
    logic found, vic_v, done, inv_any;
    logic [WayW-1:0] vic, hit_w;
    logic [AgeW-1:0] vic_age;
    logic [LatW-1:0] t, r, w, b, lat;
    row_t row;
    row = rd_row_q;
    found = 1'b0; done = 1'b0; inv_any = 1'b0;
    vic = '0; hit_w = '0;
    vic_v = row[0].valid; vic_age = row[0].age;
    t = LatW'(cfg.tag_latency); r = LatW'(cfg.read_latency);
    w = LatW'(cfg.write_latency); b = LatW'(cfg.line_burst_cycles);
    lat = '0;
    rsp_d = '0;
    if (!cfg.cache_enable) begin
      lat = op_q ? w : r;
    end else if (!op_q || cfg.write_back_mode || cfg.allocate_on_write) begin
      for (int i = 0; i < NUM_WAYS; i++) begin
        if (!done) begin
          if (row[i].valid) begin
            if (row[i].age != '1) row[i].age = row[i].age + 1'b1;
            if (!found && row[i].tag == tag_q) begin
              found = 1'b1; hit_w = WayW'(i);
              if (op_q) done = 1'b1;
            end
            if (!done && vic_v && row[i].age > vic_age) begin
              vic = WayW'(i); vic_age = row[i].age;
            end
          end else begin
            vic = WayW'(i); vic_v = 1'b0; vic_age = row[i].age;
          end
        end
      end
      // When the victim is way 0, vic_v is set again from that way's valid flag.
      if (vic == '0) vic_v = row[0].valid;
      if (found) begin
        rsp_d.hit = 1'b1;
        if (!op_q) begin
          row[hit_w].age = '0; lat = t;
        end else if (cfg.write_back_mode) begin
          row[hit_w].dirty = 1'b1; lat = t;
        end else begin
          lat = w;
        end
      end else begin
        rsp_d.allocated = 1'b1;
        rsp_d.evicted = row[vic].valid;
        if (!op_q) begin
          lat = t + r + b;
          if (row[vic].valid && row[vic].dirty) begin
            rsp_d.dirty_evicted = 1'b1;
            lat = lat + w + b;
          end
          row[vic].dirty = 1'b0;
        end else if (cfg.write_back_mode) begin
          lat = t + r + b; row[vic].dirty = 1'b1;
        end else begin
          lat = ((w > t) ? w : t) + r + b; row[vic].dirty = 1'b0;
        end
        row[vic].valid = 1'b1; row[vic].tag = tag_q; row[vic].age = '0;
      end
    end else begin
      if (cfg.invalidate_on_write) begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (row[i].valid && row[i].tag == tag_q) begin
            row[i].valid = 1'b0; inv_any = 1'b1;
          end
        end
      end
      rsp_d.hit = inv_any; rsp_d.invalidated = inv_any;
      lat = w;
    end
    rsp_d.latency = lat;
    new_row = row;
  end

  always_comb begin
    wr_en = 1'b0; wr_addr = set_q; wr_row = new_row;
    if (state_q == ctlm_pkg::StClear) begin
      wr_en = 1'b1; wr_addr = clr_cnt_q[SetW-1:0]; wr_row = '0;
    end else if (state_q == ctlm_pkg::StLookup) begin
      wr_en = 1'b1;
    end
  end
endmodule
`default_nettype wire

[design/ctlm_regs.sv]
// APB register file of the cache tag latency model.
// Depends on ctlm_pkg.
`default_nettype none
module ctlm_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ctlm_pkg::PaddrW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output ctlm_pkg::cfg_t                     cfg_o
);
  ctlm_pkg::cfg_t cfg_q;
  ctlm_pkg::reg_idx_e idx;
  logic in_range;

  assign idx      = ctlm_pkg::reg_idx_e'(paddr[4:2]);
  assign in_range = (paddr[1:0] == 2'b00);
  assign pready   = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cache_enable        <= 1'b1;
      cfg_q.read_latency        <= 16'd10;
      cfg_q.write_latency       <= 16'd10;
      cfg_q.tag_latency         <= 16'd1;
      cfg_q.line_burst_cycles   <= 16'd8;
      cfg_q.write_back_mode     <= 1'b0;
      cfg_q.allocate_on_write   <= 1'b0;
      cfg_q.invalidate_on_write <= 1'b1;
    end else if (psel && penable && pwrite && in_range) begin
      unique case (idx)
        ctlm_pkg::RegCacheEnable:  cfg_q.cache_enable        <= pwdata[0];
        ctlm_pkg::RegReadLat:      cfg_q.read_latency        <= pwdata[15:0];
        ctlm_pkg::RegWriteLat:     cfg_q.write_latency       <= pwdata[15:0];
        ctlm_pkg::RegTagLat:       cfg_q.tag_latency         <= pwdata[15:0];
        ctlm_pkg::RegBurst:        cfg_q.line_burst_cycles   <= pwdata[15:0];
        ctlm_pkg::RegWriteBack:    cfg_q.write_back_mode     <= pwdata[0];
        ctlm_pkg::RegAllocOnWrite: cfg_q.allocate_on_write   <= pwdata[0];
        ctlm_pkg::RegInvOnWrite:   cfg_q.invalidate_on_write <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (in_range) begin
      unique case (idx)
        ctlm_pkg::RegCacheEnable:  prdata[0]    = cfg_q.cache_enable;
        ctlm_pkg::RegReadLat:      prdata[15:0] = cfg_q.read_latency;
        ctlm_pkg::RegWriteLat:     prdata[15:0] = cfg_q.write_latency;
        ctlm_pkg::RegTagLat:       prdata[15:0] = cfg_q.tag_latency;
        ctlm_pkg::RegBurst:        prdata[15:0] = cfg_q.line_burst_cycles;
        ctlm_pkg::RegWriteBack:    prdata[0]    = cfg_q.write_back_mode;
        ctlm_pkg::RegAllocOnWrite: prdata[0]    = cfg_q.allocate_on_write;
        ctlm_pkg::RegInvOnWrite:   prdata[0]    = cfg_q.invalidate_on_write;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
